// ----- src/isu_pkg.sv -----
// Package for the insertion sorter: the control word handed to every cell of the chain.
// No dependencies; used by isu_cell and insertion_sorter_unit.
`default_nettype none

package isu_pkg;

    // Per-cycle command broadcast along the chain.
    typedef struct packed {
        logic insert;   // place the broadcast value, pushing greater ones up
        logic shift;    // move every cell one place towards cell 0
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- src/isu_cell.sv -----
// One cell of the sorting chain: one stored value, its valid bit and the compare.
// Depends on isu_pkg for the control word.
`default_nettype none

module isu_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire isu_pkg::cell_ctrl_t     ctrl,
    input  wire logic signed [VALUE_WIDTH-1:0] new_value,
    input  wire logic signed [VALUE_WIDTH-1:0] prev_value,
    input  wire                          prev_valid,
    input  wire                          prev_gt,
    input  wire logic signed [VALUE_WIDTH-1:0] next_value,
    input  wire                          next_valid,
    output logic signed [VALUE_WIDTH-1:0] value,
    output logic                         valid,
    output logic                         gt
);
    import isu_pkg::*;

    logic signed [VALUE_WIDTH-1:0] value_reg;
    logic signed [VALUE_WIDTH-1:0] value_next;
    logic                          valid_reg;
    logic                          valid_next;

    // Strict compare keeps equal values in arrival order.
    assign gt    = valid_reg && (new_value < value_reg);
    assign value = value_reg;
    assign valid = valid_reg;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
        else if (ctrl.insert)
        begin
            if (prev_gt)
            begin
                // take the neighbour pushed up by the new value
                value_next = prev_value;
                valid_next = 1'b1;
            end
            else if (gt || (!valid_reg && prev_valid))
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

// ----- src/insertion_sorter_unit.sv -----
// Channel   Handshake                  Fields
// item      item_valid / item_ready    value, end_of_set
// result    result_valid / result_ready  sorted_value, end_of_run, overflow
//
// Each item is inserted into the chain of cells, every cell comparing at once, unless the
// last cell is full: then it is dropped and overflow stays set until the run ends.
// The item flagged end_of_set starts the drain: one result per cycle from cell 0 while
// result_ready is high, the chain shifting down on each taken result; no item is taken
// until the last result leaves. A run gives one result per stored value, at most MAX_ITEMS.
// Reset clears the valid bits, the drain state and the overflow flag.
// Depends on isu_pkg and isu_cell.
`default_nettype none

module insertion_sorter_unit #(
    parameter int MAX_ITEMS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          item_valid,
    output logic                         item_ready,
    input  wire logic signed [VALUE_WIDTH-1:0] value,
    input  wire                          end_of_set,
    output logic                         result_valid,
    input  wire                          result_ready,
    output logic signed [VALUE_WIDTH-1:0] sorted_value,
    output logic                         end_of_run,
    output logic                         overflow
);
    import isu_pkg::*;

    logic signed [VALUE_WIDTH-1:0] cell_value [MAX_ITEMS];
    logic                          cell_valid [MAX_ITEMS];
    logic                          cell_gt    [MAX_ITEMS];

    cell_ctrl_t ctrl;
    logic       item_acc;
    logic       result_acc;
    logic       store_full;
    logic       draining_reg;
    logic       draining_next;
    logic       dropped_reg;
    logic       dropped_next;

    assign item_ready  = !draining_reg;
    assign item_acc    = item_valid && item_ready;
    assign result_acc  = result_valid && result_ready;
    assign store_full  = cell_valid[MAX_ITEMS-1];

    assign ctrl.insert = item_acc && !store_full;
    assign ctrl.shift  = result_acc;

    // Head of the chain is the smallest stored value.
    assign result_valid = draining_reg;
    assign sorted_value = cell_value[0];
    assign end_of_run   = !cell_valid[1];
    assign overflow     = dropped_reg;

    genvar i;
    generate
        for (i = 0; i < MAX_ITEMS; i++)
        begin : g_cell
            logic signed [VALUE_WIDTH-1:0] prev_value;
            logic                          prev_valid;
            logic                          prev_gt;
            logic signed [VALUE_WIDTH-1:0] next_value;
            logic                          next_valid;

            if (i == 0)
            begin : g_first
                assign prev_value = value;
                assign prev_valid = 1'b1;
                assign prev_gt    = 1'b0;
            end
            else
            begin : g_mid
                assign prev_value = cell_value[i-1];
                assign prev_valid = cell_valid[i-1];
                assign prev_gt    = cell_gt[i-1];
            end

            if (i == MAX_ITEMS - 1)
            begin : g_last
                assign next_value = value;
                assign next_valid = 1'b0;
            end
            else
            begin : g_inner
                assign next_value = cell_value[i+1];
                assign next_valid = cell_valid[i+1];
            end

            isu_cell #(
                .VALUE_WIDTH(VALUE_WIDTH)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .new_value (value),
                .prev_value(prev_value),
                .prev_valid(prev_valid),
                .prev_gt   (prev_gt),
                .next_value(next_value),
                .next_valid(next_valid),
                .value     (cell_value[i]),
                .valid     (cell_valid[i]),
                .gt        (cell_gt[i])
            );
        end
    endgenerate

    always_comb
    begin
        draining_next = draining_reg;
        dropped_next  = dropped_reg;
        if (item_acc)
        begin
            // drop the value when full, but flag the overflow for the run
            if (store_full)
            begin
                dropped_next = 1'b1;
            end
            if (end_of_set)
            begin
                draining_next = 1'b1;
            end
        end
        if (result_acc && end_of_run)
        begin
            draining_next = 1'b0;
            dropped_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draining_reg <= 1'b0;
            dropped_reg  <= 1'b0;
        end
        else
        begin
            draining_reg <= draining_next;
            dropped_reg  <= dropped_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/isu_checker.sv -----
// Port-level checks for insertion_sorter_unit, bound to the top level.
// Depends only on the ports of insertion_sorter_unit.
`default_nettype none

module isu_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          item_valid,
    input wire                          item_ready,
    input wire                          end_of_set,
    input wire                          result_valid,
    input wire                          result_ready,
    input wire logic signed [VALUE_WIDTH-1:0] sorted_value,
    input wire                          end_of_run
);

    // No item is taken while a run is being given out.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !item_ready)
        else $error("item ready during drain");

    // Closing item starts the run in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && end_of_set |=> result_valid)
        else $error("no result after end of set");

    // Run continues until its last item.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !end_of_run |=> result_valid)
        else $error("run ended early");

    // Run stops after its last item.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && end_of_run |=> !result_valid)
        else $error("result after end of run");

    // Stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(sorted_value))
        else $error("stalled result changed");

endmodule

bind insertion_sorter_unit isu_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_isu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .end_of_set  (end_of_set),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .sorted_value(sorted_value),
    .end_of_run  (end_of_run)
);

`default_nettype wire
